FILE: src/rlq_pkg.sv
// request and response types, mode and status codes for the reentrant lock queue
// no dependencies
package rlq_pkg;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] thread_id;
  } lock_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       wake_valid;
    logic [7:0] wake_thread;
    logic       held_by_caller;
    logic       owner_valid;
    logic [7:0] owner_id;
  } lock_rsp_t;

  localparam int unsigned FIELD_ID_BITS = 8;

  localparam logic [1:0] MODE_ACQUIRE = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_NOT_OWNER = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

endpackage

FILE: src/reentrant_lock_queue.sv
// reentrant mutex with a fifo of waiting thread ids and direct hand-off on release
// depends on rlq_pkg (request/response structs, mode and status codes)
//
//  channel | direction | payload                      | handshake
//  in_     | input     | rlq_pkg::lock_req_t in_req   | in_valid / in_stall
//  out_    | output    | rlq_pkg::lock_rsp_t out_rsp  | out_valid / out_stall
//
// a request is taken in S_IDLE, where the waiter memory is read at the queue head;
// the update state S_EXEC then reads owner/count, updates them and writes the queue tail;
// the registered memory read is why the update needs a state of its own
// reset is synchronous, active low; it clears owner, count and queue pointers, the
// waiter memory itself is not cleared (only entries counted in the fill are read)
// a result sits in the output register until taken; while it is stalled the next
// request waits in its update cycle and no further request is taken
module reentrant_lock_queue #(
  parameter int THREAD_ID_BITS = 8,
  parameter int QUEUE_DEPTH    = 16,
  parameter int COUNT_BITS     = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rlq_pkg::lock_req_t in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output rlq_pkg::lock_rsp_t out_rsp
);

  localparam int TW = THREAD_ID_BITS;
  localparam int FB = rlq_pkg::FIELD_ID_BITS;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QW-1:0] LAST_SLOT = QW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(QUEUE_DEPTH);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t             state_r;
  logic [1:0]         mode_r;
  logic [TW-1:0]      tid_r;
  logic [TW-1:0]      rd_data_r;
  logic               busy_r;
  logic [TW-1:0]      owner_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [QW-1:0]      head_r;
  logic [QW-1:0]      tail_r;
  logic [FW-1:0]      fill_r;
  logic               out_valid_r;
  rlq_pkg::lock_rsp_t out_rsp_r;

  logic               busy_nxt;
  logic [TW-1:0]      owner_nxt;
  logic [COUNT_BITS-1:0] count_nxt;
  logic [QW-1:0]      head_nxt;
  logic [QW-1:0]      tail_nxt;
  logic [FW-1:0]      fill_nxt;
  rlq_pkg::lock_rsp_t out_rsp_nxt;

  logic [TW-1:0]      waiter_mem [QUEUE_DEPTH];

  logic               in_fire;
  logic               exec_go;
  logic               held;
  logic               enqueue;
  logic [COUNT_BITS-1:0] count_dec;
  logic [TW+FB-1:0]   tid_ext;
  logic [TW+FB-1:0]   owner_ext;
  logic [TW+FB-1:0]   wake_ext;
  logic [TW-1:0]      wake_tid;
  logic               wake_v;
  logic [2:0]         status;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // only the low THREAD_ID_BITS of the id count
  assign tid_ext   = {TW'(0), in_req.thread_id};
  assign held      = busy_r && (owner_r == tid_r);
  assign count_dec = count_r - COUNT_BITS'(1);

  always_comb begin
    busy_nxt  = busy_r;
    owner_nxt = owner_r;
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    fill_nxt  = fill_r;
    status    = rlq_pkg::ST_DONE;
    wake_v    = 1'b0;
    wake_tid  = '0;
    enqueue   = 1'b0;
    case (mode_r)
      rlq_pkg::MODE_ACQUIRE: begin
        if (held) begin
          if (count_r == '1) begin
            status = rlq_pkg::ST_SATURATED;
          end else begin
            count_nxt = count_r + COUNT_BITS'(1);
          end
        end else if (!busy_r) begin
          busy_nxt  = 1'b1;
          owner_nxt = tid_r;
          count_nxt = COUNT_BITS'(1);
        end else if (fill_r == FILL_FULL) begin
          status = rlq_pkg::ST_FULL;
        end else begin
          enqueue  = 1'b1;
          tail_nxt = (tail_r == LAST_SLOT) ? '0 : tail_r + QW'(1);
          fill_nxt = fill_r + FW'(1);
          status   = rlq_pkg::ST_QUEUED;
        end
      end
      rlq_pkg::MODE_RELEASE: begin
        if (!held) begin
          status = rlq_pkg::ST_NOT_OWNER;
        end else begin
          count_nxt = count_dec;
          if (count_dec == '0) begin
            if (fill_r == '0) begin
              busy_nxt  = 1'b0;
              owner_nxt = '0;
            end else begin
              // hand the lock straight to the oldest waiter
              owner_nxt = rd_data_r;
              count_nxt = COUNT_BITS'(1);
              head_nxt  = (head_r == LAST_SLOT) ? '0 : head_r + QW'(1);
              fill_nxt  = fill_r - FW'(1);
              wake_v    = 1'b1;
              wake_tid  = rd_data_r;
            end
          end
        end
      end
      rlq_pkg::MODE_QUERY: begin
        status = rlq_pkg::ST_DONE;
      end
      default: begin
        status = rlq_pkg::ST_DONE;
      end
    endcase
  end

  assign owner_ext = {FB'(0), (busy_nxt ? owner_nxt : TW'(0))};
  assign wake_ext  = {FB'(0), wake_tid};

  always_comb begin
    out_rsp_nxt.status         = status;
    out_rsp_nxt.wake_valid     = wake_v;
    out_rsp_nxt.wake_thread    = wake_ext[FB-1:0];
    out_rsp_nxt.held_by_caller = held;
    out_rsp_nxt.owner_valid    = busy_nxt;
    out_rsp_nxt.owner_id       = owner_ext[FB-1:0];
  end

  // waiter memory: head read issued with the request, tail written in the update cycle
  always_ff @(posedge clk) begin
    if (exec_go && enqueue) begin
      waiter_mem[tail_r] <= tid_r;
    end
    if (in_fire) begin
      rd_data_r <= waiter_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      owner_r     <= '0;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !exec_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            mode_r  <= in_req.mode;
            tid_r   <= tid_ext[TW-1:0];
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            busy_r      <= busy_nxt;
            owner_r     <= owner_nxt;
            count_r     <= count_nxt;
            head_r      <= head_nxt;
            tail_r      <= tail_nxt;
            fill_r      <= fill_nxt;
            out_rsp_r   <= out_rsp_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("waiter fill beyond queue depth");

  a_free_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (count_r == '0) && (fill_r == '0) && (owner_r == '0))
    else $error("free lock with count, owner or waiters left");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (count_r != '0))
    else $error("held lock with zero count");

  a_take_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("request taken without update cycle");

  a_wake_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.wake_valid) |->
      (out_rsp_r.owner_valid && (out_rsp_r.owner_id == out_rsp_r.wake_thread)))
    else $error("woken thread is not the reported owner");

endmodule
